// ===== hw/rtl/rgbhsv_pkg.sv =====
// Shared types and constants for the RGB to HSV pixel converter.
package rgbhsv_pkg;

    // Hue base per dominant channel and hue scale
    localparam logic [7:0] HUE_BASE_RED   = 8'd0;
    localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
    localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;
    localparam logic [5:0] HUE_STEP       = 6'd43;

    // Quotient bits per divider and pipeline shape
    localparam int SAT_STEPS  = 8;
    localparam int HUE_STEPS  = 6;
    localparam int DIV_STAGES = SAT_STEPS;      // divider stages after the front stage
    localparam int LAST_STAGE = DIV_STAGES + 1; // index of the output register

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       end_of_frame;
    } t_rgb_pixel;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic       frame_end;
    } t_hsv_pixel;

    // Per-stage state of the two restoring dividers
    typedef struct packed {
        logic [7:0]           sat_rem;
        logic [7:0]           sat_num;
        logic [SAT_STEPS-1:0] sat_quo;
        logic [7:0]           hue_rem;
        logic [5:0]           hue_num;
        logic [HUE_STEPS-1:0] hue_quo;
        logic [7:0]           hi;
        logic [7:0]           span;
        logic [7:0]           base;
        logic                 neg;
        logic                 zero;
        logic                 eof;
    } t_div_stage;

endpackage

// ===== hw/rtl/rgb_to_hsv_pixel_convert.sv =====
// Pipelined 8-bit RGB to 8-bit HSV pixel converter.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_pixel (red, green, blue, end_of_frame)
//  output    out        o_valid / i_stall    o_pixel (hue, saturation, brightness, frame_end)
//
// One pixel enters per clock unless the pipeline is stalled. The stages are a front
// stage (max, min, span, numerators), eight restoring-divider stages that each settle one
// saturation quotient bit (and one hue bit in the first six), and an output stage.
// Reset (synchronous, active low) clears the valid bits only.
// Each stage holds while it is full and the stage after it holds, so bubbles
// close up and a stall at the output loses or repeats no pixel.
module rgb_to_hsv_pixel_convert (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  rgbhsv_pkg::t_rgb_pixel  i_pixel,
    output logic                    o_valid,
    input  logic                    i_stall,
    output rgbhsv_pkg::t_hsv_pixel  o_pixel
);

    localparam int NS = rgbhsv_pkg::LAST_STAGE;

    logic                   r_valid [0:NS];
    rgbhsv_pkg::t_div_stage r_pipe  [0:NS-1];
    rgbhsv_pkg::t_div_stage n_pipe  [0:NS-1];
    rgbhsv_pkg::t_hsv_pixel r_out;
    rgbhsv_pkg::t_hsv_pixel n_out;
    logic                   adv     [0:NS];

    // front stage signals
    logic [7:0]  hi, lo, span;
    logic [8:0]  diff;
    logic [7:0]  abs_diff;
    logic [15:0] sat_n;
    logic [13:0] hue_n;
    logic [7:0]  q_ext;

    // One restoring step: bring in the numerator MSB, subtract if it fits
    function automatic rgbhsv_pkg::t_div_stage div_step(
        input rgbhsv_pkg::t_div_stage s,
        input logic                   do_hue
    );
        rgbhsv_pkg::t_div_stage o;
        logic [8:0] ts;
        logic [8:0] th;
        o  = s;
        ts = {s.sat_rem, s.sat_num[7]};
        o.sat_num = {s.sat_num[6:0], 1'b0};
        if (ts >= {1'b0, s.hi}) begin
            o.sat_rem = 8'(ts - {1'b0, s.hi});
            o.sat_quo = {s.sat_quo[rgbhsv_pkg::SAT_STEPS-2:0], 1'b1};
        end else begin
            o.sat_rem = ts[7:0];
            o.sat_quo = {s.sat_quo[rgbhsv_pkg::SAT_STEPS-2:0], 1'b0};
        end
        if (do_hue) begin
            th = {s.hue_rem, s.hue_num[5]};
            o.hue_num = {s.hue_num[4:0], 1'b0};
            if (th >= {1'b0, s.span}) begin
                o.hue_rem = 8'(th - {1'b0, s.span});
                o.hue_quo = {s.hue_quo[rgbhsv_pkg::HUE_STEPS-2:0], 1'b1};
            end else begin
                o.hue_rem = th[7:0];
                o.hue_quo = {s.hue_quo[rgbhsv_pkg::HUE_STEPS-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Advance chain: a stage moves when empty or when the next one moves
    always_comb begin
        adv[NS] = !r_valid[NS] || !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_valid[NS];
    assign o_pixel = r_out;

    // Front stage: max, min, span, signed channel difference, numerators
    always_comb begin
        hi = i_pixel.red;
        if (i_pixel.green > hi) hi = i_pixel.green;
        if (i_pixel.blue > hi)  hi = i_pixel.blue;
        lo = i_pixel.red;
        if (i_pixel.green < lo) lo = i_pixel.green;
        if (i_pixel.blue < lo)  lo = i_pixel.blue;
        span = hi - lo;

        n_pipe[0] = '0;
        if (hi == i_pixel.red) begin
            diff           = {1'b0, i_pixel.green} - {1'b0, i_pixel.blue};
            n_pipe[0].base = rgbhsv_pkg::HUE_BASE_RED;
        end else if (hi == i_pixel.green) begin
            diff           = {1'b0, i_pixel.blue} - {1'b0, i_pixel.red};
            n_pipe[0].base = rgbhsv_pkg::HUE_BASE_GREEN;
        end else begin
            diff           = {1'b0, i_pixel.red} - {1'b0, i_pixel.green};
            n_pipe[0].base = rgbhsv_pkg::HUE_BASE_BLUE;
        end
        abs_diff = diff[8] ? 8'(-diff) : diff[7:0];
        sat_n    = {span, 8'd0} - {8'd0, span};
        hue_n    = {6'd0, abs_diff} * {8'd0, rgbhsv_pkg::HUE_STEP};

        n_pipe[0].sat_rem = sat_n[15:8];
        n_pipe[0].sat_num = sat_n[7:0];
        n_pipe[0].hue_rem = hue_n[13:6];
        n_pipe[0].hue_num = hue_n[5:0];
        n_pipe[0].hi      = hi;
        n_pipe[0].span    = span;
        n_pipe[0].neg     = diff[8];
        n_pipe[0].zero    = (span == 8'd0);
        n_pipe[0].eof     = i_pixel.end_of_frame;

        // Divider stages
        for (int k = 1; k < NS; k++) begin
            n_pipe[k] = div_step(r_pipe[k-1], k <= rgbhsv_pkg::HUE_STEPS);
        end
    end

    // Output stage: apply sign, add base, drop results for grey and black
    always_comb begin
        q_ext            = {2'b00, r_pipe[NS-1].hue_quo};
        n_out.brightness = r_pipe[NS-1].hi;
        n_out.frame_end  = r_pipe[NS-1].eof;
        if (r_pipe[NS-1].zero) begin
            n_out.hue        = 8'd0;
            n_out.saturation = 8'd0;
        end else begin
            n_out.hue        = r_pipe[NS-1].neg ? r_pipe[NS-1].base - q_ext
                                                : r_pipe[NS-1].base + q_ext;
            n_out.saturation = r_pipe[NS-1].sat_quo;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (adv[0]) r_valid[0] <= i_valid;
            for (int k = 1; k <= NS; k++) begin
                if (adv[k]) r_valid[k] <= r_valid[k-1];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (adv[k]) r_pipe[k] <= n_pipe[k];
        end
        if (adv[NS]) r_out <= n_out;
    end

endmodule

// ===== bench/tb_rgb_to_hsv_pixel_convert.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined RGB to HSV pixel converter.
module tb_rgb_to_hsv_pixel_convert;

    localparam int CLK_HALF_NS      = 4;
    localparam int RESET_CYCLES     = 10;
    localparam int PIPE_LATENCY     = rgbhsv_pkg::LAST_STAGE + 1;
    localparam int RANDOM_PER_PHASE = 600;
    localparam int TIMEOUT_NS       = 2_000_000;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    rgbhsv_pkg::t_rgb_pixel i_pixel = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    rgbhsv_pkg::t_hsv_pixel o_pixel;

    // HSV pixels owed by the converter, oldest first
    rgbhsv_pkg::t_hsv_pixel pending_hsv_q[$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;

    rgb_to_hsv_pixel_convert uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Compute the HSV pixel the converter should give for one RGB pixel
    function automatic rgbhsv_pkg::t_hsv_pixel hsv_from_rgb(input rgbhsv_pkg::t_rgb_pixel px);
        int         r;
        int         g;
        int         b;
        int         hi;
        int         lo;
        int         span;
        int         base;
        int         diff;
        int         hue_sum;
        rgbhsv_pkg::t_hsv_pixel hsv;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        span = hi - lo;
        hsv = '0;
        hsv.brightness = 8'(hi);
        hsv.frame_end  = px.end_of_frame;
        // black and grey keep hue and saturation at zero
        if (hi != 0 && span != 0) begin
            hsv.saturation = 8'((255 * span) / hi);
            // ties go to red first, then green
            if (hi == r) begin
                base = int'(rgbhsv_pkg::HUE_BASE_RED);
                diff = g - b;
            end else if (hi == g) begin
                base = int'(rgbhsv_pkg::HUE_BASE_GREEN);
                diff = b - r;
            end else begin
                base = int'(rgbhsv_pkg::HUE_BASE_BLUE);
                diff = r - g;
            end
            // signed quotient truncates toward zero; the sum wraps to 8 bits
            hue_sum = base + (int'(rgbhsv_pkg::HUE_STEP) * diff) / span;
            hsv.hue = 8'(hue_sum);
        end
        return hsv;
    endfunction

    function automatic rgbhsv_pkg::t_rgb_pixel make_pixel(
        input logic [7:0] r, input logic [7:0] g,
        input logic [7:0] b, input logic eof
    );
        rgbhsv_pkg::t_rgb_pixel px;
        px.red          = r;
        px.green        = g;
        px.blue         = b;
        px.end_of_frame = eof;
        return px;
    endfunction

    // Draw a pixel: half uniform, the rest near-grey, tied, extreme or near-black mixes
    function automatic rgbhsv_pkg::t_rgb_pixel random_pixel();
        rgbhsv_pkg::t_rgb_pixel px;
        logic [7:0] lvl;
        logic [7:0] other;
        px.red          = 8'($urandom);
        px.green        = 8'($urandom);
        px.blue         = 8'($urandom);
        px.end_of_frame = ($urandom_range(15) == 0);
        lvl   = 8'($urandom);
        other = 8'($urandom);
        case ($urandom_range(7))
            4: begin
                lvl = 8'($urandom_range(252));
                px.red   = lvl + 8'($urandom_range(3));
                px.green = lvl + 8'($urandom_range(3));
                px.blue  = lvl + 8'($urandom_range(3));
            end
            5: begin
                case ($urandom_range(3))
                    0: px = make_pixel(lvl, lvl, other, px.end_of_frame);
                    1: px = make_pixel(other, lvl, lvl, px.end_of_frame);
                    2: px = make_pixel(lvl, other, lvl, px.end_of_frame);
                    default: px = make_pixel(lvl, lvl, lvl, px.end_of_frame);
                endcase
            end
            6: begin
                px.red   = $urandom_range(1) ? 8'hFF - 8'($urandom_range(1))
                                             : 8'($urandom_range(1));
                px.green = $urandom_range(1) ? 8'hFF - 8'($urandom_range(1))
                                             : 8'($urandom_range(1));
                px.blue  = $urandom_range(1) ? 8'hFF - 8'($urandom_range(1))
                                             : 8'($urandom_range(1));
            end
            7: begin
                px.red   = 8'($urandom_range(3));
                px.green = 8'($urandom_range(3));
                px.blue  = 8'($urandom_range(3));
            end
            default: ;
        endcase
        return px;
    endfunction

    // Send one request: idle a random gap, then hold it until accepted
    task automatic send_pixel(input rgbhsv_pkg::t_rgb_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            i_pixel <= random_pixel();
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
        pending_hsv_q.push_back(hsv_from_rgb(px));
    endtask

    // Drop valid and wait until every owed pixel has come out
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_hsv_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatch_count++;
    endtask

    // Check each accepted result against the oldest owed pixel; drive stall
    always @(posedge i_clk) begin
        rgbhsv_pkg::t_hsv_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_hsv_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual h=%0d s=%0d v=%0d e=%0d",
                         $time, o_pixel.hue, o_pixel.saturation, o_pixel.brightness,
                         o_pixel.frame_end);
                mismatch_count++;
            end else begin
                want = pending_hsv_q.pop_front();
                if (o_pixel.hue !== want.hue)
                    report_field("hue", want.hue, o_pixel.hue);
                if (o_pixel.saturation !== want.saturation)
                    report_field("saturation", want.saturation, o_pixel.saturation);
                if (o_pixel.brightness !== want.brightness)
                    report_field("brightness", want.brightness, o_pixel.brightness);
                if (o_pixel.frame_end !== want.frame_end)
                    report_field("frame_end", 8'(want.frame_end), 8'(o_pixel.frame_end));
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Black, white and grey pixels
    task automatic test_special_pixels();
        send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   1'b0));
        send_pixel(make_pixel(8'd0,   8'd0,   8'd0,   1'b1));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
        send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 1'b0));
        send_pixel(make_pixel(8'd1,   8'd1,   8'd1,   1'b1));
    endtask

    // Each dominant channel, ties between channels and negative hue wrap
    task automatic test_hue_sectors();
        send_pixel(make_pixel(8'd255, 8'd0,   8'd0,   1'b0));
        send_pixel(make_pixel(8'd0,   8'd255, 8'd0,   1'b0));
        send_pixel(make_pixel(8'd0,   8'd0,   8'd255, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd0,   1'b0));
        send_pixel(make_pixel(8'd0,   8'd255, 8'd255, 1'b0));
        send_pixel(make_pixel(8'd255, 8'd0,   8'd255, 1'b1));
        send_pixel(make_pixel(8'd200, 8'd10,  8'd100, 1'b0));
        send_pixel(make_pixel(8'd90,  8'd200, 8'd30,  1'b0));
        send_pixel(make_pixel(8'd100, 8'd3,   8'd250, 1'b0));
    endtask

    // Smallest spans and alternating bit patterns on every channel
    task automatic test_channel_extremes();
        send_pixel(make_pixel(8'd1,   8'd0,   8'd0,   1'b0));
        send_pixel(make_pixel(8'd0,   8'd1,   8'd0,   1'b0));
        send_pixel(make_pixel(8'd0,   8'd0,   8'd1,   1'b0));
        send_pixel(make_pixel(8'd255, 8'd254, 8'd254, 1'b0));
        send_pixel(make_pixel(8'd254, 8'd255, 8'd255, 1'b0));
        send_pixel(make_pixel(8'hAA,  8'h55,  8'hAA,  1'b0));
        send_pixel(make_pixel(8'h55,  8'hAA,  8'h55,  1'b1));
    endtask

    task automatic test_random_pixels(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // slow receiver
        send_idle_pct = 22;
        recv_idle_pct = 80;
        test_special_pixels();
        test_hue_sectors();
        test_channel_extremes();
        test_random_pixels(RANDOM_PER_PHASE);
        wait_for_results();

        // slow sender
        send_idle_pct = 80;
        recv_idle_pct = 22;
        test_random_pixels(RANDOM_PER_PHASE);
        wait_for_results();

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_pixels(RANDOM_PER_PHASE);
        wait_for_results();

        // let any stray result surface
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", pending_hsv_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
